// ----- design/latitude_cell_geometry_macros.svh -----
// assertion macros for the latitude cell geometry checker
// expects i_clk and i_rst_n in the scope where the macros are used
`ifndef LATITUDE_CELL_GEOMETRY_MACROS_SVH
`define LATITUDE_CELL_GEOMETRY_MACROS_SVH

// same-cycle implication, held off during reset
`define LCG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define LCG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lcg_pkg.sv -----
// shared types, widths and constants for the latitude cell geometry block
// no dependencies; used by the cordic cell, the divider cell, the ratio divider and the top level
`timescale 1ns / 1ps
`default_nettype none

package lcg_pkg;

    localparam int CORDIC_STEPS_DEF = 24;

    localparam int ROW_W    = 12;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int SOUTH_W  = 32;
    localparam int STEP_W   = 28;
    localparam int LAT_W    = 42;
    localparam int RED_W    = 41;
    localparam int FOLD_W   = 32;
    localparam int ANG_W    = 33;
    localparam int XY_W     = 33;
    localparam int BASE_W   = 31;
    localparam int PROD_W   = 65;
    localparam int EDGE_W   = 32;
    localparam int EW_W     = 32;
    localparam int NS_W     = 29;
    localparam int EW_OUT_W = 30;
    localparam int AREA_W   = 42;
    localparam int APROD_W  = 62;
    localparam int RATIO_W  = 32;

    localparam int MOD_STAGES = 9;
    localparam int Q_BITS     = 33;
    localparam int DIV_LAT    = Q_BITS + 3;

    localparam int NUM0_W = NS_W + 17;
    localparam int DEN0_W = EW_W;
    localparam int NUM1_W = EDGE_W + 16;
    localparam int DEN1_W = NS_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SOUTH_EDGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NS_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EW_STEP    = 2'd2;

    localparam logic signed [SOUTH_W-1:0] SOUTH_RESET = 32'sd0;
    localparam logic [STEP_W-1:0]         STEP_RESET  = 28'd139810;

    localparam logic [32:0] MPD_Q16 = 33'd7287270713;
    localparam logic [16:0] MPD_LO  = MPD_Q16[16:0];
    localparam logic [15:0] MPD_HI  = MPD_Q16[32:17];

    localparam logic [RED_W-1:0]  DEG_FULL      = 41'd6039797760;
    localparam logic [RED_W-1:0]  DEG_HALF      = 41'd3019898880;
    localparam logic [FOLD_W-1:0] DEG_HALF_F    = 32'd3019898880;
    localparam logic [FOLD_W-1:0] DEG_QUARTER_F = 32'd1509949440;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [31:0] ATAN_DEG [32] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234683,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115,
        32'd57,        32'd29,        32'd14,        32'd7,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        logic                    neg;
    } t_lane;

    typedef struct packed {
        logic sgn;
        logic num_zero;
        logic den_zero;
        logic ovf;
    } t_div_ctl;

endpackage

`default_nettype wire

// ----- design/lcg_cordic_cell.sv -----
// one cordic rotation step for the south and north edge lanes
// depends on lcg_pkg for the lane type and the arctangent table
`timescale 1ns / 1ps
`default_nettype none

module lcg_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  lcg_pkg::t_lane [1:0]    i_lane,
    output lcg_pkg::t_lane [1:0]    o_lane
);
    import lcg_pkg::*;

    localparam logic signed [ANG_W-1:0] ATAN_Z = ANG_W'(ATAN_DEG[STEP]);

    t_lane [1:0] n_lane;
    t_lane [1:0] r_lane;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_lane[l] = i_lane[l];
            if (!i_lane[l].z[ANG_W-1]) begin
                n_lane[l].x = i_lane[l].x - (i_lane[l].y >>> STEP);
                n_lane[l].y = i_lane[l].y + (i_lane[l].x >>> STEP);
                n_lane[l].z = i_lane[l].z - ATAN_Z;
            end else begin
                n_lane[l].x = i_lane[l].x + (i_lane[l].y >>> STEP);
                n_lane[l].y = i_lane[l].y - (i_lane[l].x >>> STEP);
                n_lane[l].z = i_lane[l].z + ATAN_Z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

// ----- design/lcg_div_cell.sv -----
// one restoring division step producing quotient bit K
// depends on lcg_pkg for the divider control type
`timescale 1ns / 1ps
`default_nettype none

module lcg_div_cell #(
    parameter int NUM_W = lcg_pkg::NUM0_W,
    parameter int DEN_W = lcg_pkg::DEN0_W,
    parameter int K     = 0
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [NUM_W-1:0]            i_rem,
    input  logic [DEN_W-1:0]            i_den,
    input  logic [lcg_pkg::Q_BITS-1:0]  i_quo,
    input  lcg_pkg::t_div_ctl           i_ctl,
    output logic [NUM_W-1:0]            o_rem,
    output logic [DEN_W-1:0]            o_den,
    output logic [lcg_pkg::Q_BITS-1:0]  o_quo,
    output lcg_pkg::t_div_ctl           o_ctl
);
    import lcg_pkg::*;

    localparam int CW = DEN_W + Q_BITS;

    logic [CW-1:0]     rem_ext;
    logic [CW-1:0]     den_sh;
    logic [CW-1:0]     diff;
    logic              ge;
    logic [NUM_W-1:0]  n_rem;
    logic [Q_BITS-1:0] n_quo;

    logic [NUM_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [Q_BITS-1:0] r_quo;
    t_div_ctl          r_ctl;

    always_comb begin
        rem_ext = CW'(i_rem);
        den_sh  = CW'(i_den) << K;
        diff    = rem_ext - den_sh;
        ge      = rem_ext >= den_sh;
        n_rem   = ge ? diff[NUM_W-1:0] : i_rem;
        n_quo   = i_quo;
        n_quo[K] = ge;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_quo <= n_quo;
            r_ctl <= i_ctl;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;
    assign o_ctl = r_ctl;

endmodule

`default_nettype wire

// ----- design/lcg_ratio_div.sv -----
// pipelined signed q16.16 ratio divider with saturation, one word per cycle while i_en is high
// depends on lcg_pkg and lcg_div_cell
`timescale 1ns / 1ps
`default_nettype none

module lcg_ratio_div #(
    parameter int NUM_W = lcg_pkg::NUM0_W,
    parameter int DEN_W = lcg_pkg::DEN0_W
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [NUM_W-1:0]             i_num,
    input  logic signed [DEN_W-1:0]             i_den,
    output logic signed [lcg_pkg::RATIO_W-1:0]  o_quo
);
    import lcg_pkg::*;

    localparam int CW = DEN_W + Q_BITS;
    localparam logic [Q_BITS-1:0]  Q_POS_MAX = 33'h0_7FFF_FFFF;
    localparam logic [Q_BITS-1:0]  Q_NEG_MAX = 33'h0_8000_0000;
    localparam logic [RATIO_W-1:0] SAT_POS   = 32'h7FFF_FFFF;
    localparam logic [RATIO_W-1:0] SAT_NEG   = 32'h8000_0000;

    logic [NUM_W-1:0]  n_rem0;
    logic [DEN_W-1:0]  n_den0;
    t_div_ctl          n_ctl0;
    logic [NUM_W-1:0]  r_rem0;
    logic [DEN_W-1:0]  r_den0;
    t_div_ctl          r_ctl0;

    t_div_ctl          n_ctl1;
    logic [NUM_W-1:0]  r_rem1;
    logic [DEN_W-1:0]  r_den1;
    t_div_ctl          r_ctl1;

    logic [NUM_W-1:0]  rem_w [Q_BITS+1];
    logic [DEN_W-1:0]  den_w [Q_BITS+1];
    logic [Q_BITS-1:0] quo_w [Q_BITS+1];
    t_div_ctl          ctl_w [Q_BITS+1];

    logic [Q_BITS-1:0]  q_fin;
    logic [Q_BITS-1:0]  q_neg;
    t_div_ctl           c_fin;
    logic [RATIO_W-1:0] n_quo;
    logic [RATIO_W-1:0] r_quo;

    always_comb begin
        n_rem0 = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        n_den0 = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
        n_ctl0.sgn      = i_num[NUM_W-1] ^ i_den[DEN_W-1];
        n_ctl0.num_zero = (i_num == '0);
        n_ctl0.den_zero = (i_den == '0);
        n_ctl0.ovf      = 1'b0;
    end

    always_comb begin
        n_ctl1     = r_ctl0;
        n_ctl1.ovf = CW'(r_rem0) >= (CW'(r_den0) << Q_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0 <= n_rem0;
            r_den0 <= n_den0;
            r_ctl0 <= n_ctl0;
            r_rem1 <= r_rem0;
            r_den1 <= r_den0;
            r_ctl1 <= n_ctl1;
        end
    end

    assign rem_w[0] = r_rem1;
    assign den_w[0] = r_den1;
    assign quo_w[0] = '0;
    assign ctl_w[0] = r_ctl1;

    for (genvar g = 0; g < Q_BITS; g++) begin : g_step
        lcg_div_cell #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W),
            .K     (Q_BITS - 1 - g)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (rem_w[g]),
            .i_den (den_w[g]),
            .i_quo (quo_w[g]),
            .i_ctl (ctl_w[g]),
            .o_rem (rem_w[g+1]),
            .o_den (den_w[g+1]),
            .o_quo (quo_w[g+1]),
            .o_ctl (ctl_w[g+1])
        );
    end

    always_comb begin
        q_fin = quo_w[Q_BITS];
        c_fin = ctl_w[Q_BITS];
        q_neg = Q_BITS'(0) - q_fin;
        if (c_fin.num_zero) begin
            n_quo = '0;
        end else if (!c_fin.sgn) begin
            n_quo = (c_fin.ovf || q_fin > Q_POS_MAX) ? SAT_POS : q_fin[RATIO_W-1:0];
        end else begin
            n_quo = (c_fin.ovf || q_fin > Q_NEG_MAX) ? SAT_NEG : q_neg[RATIO_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

`default_nettype wire

// ----- design/latitude_cell_geometry.sv -----
// top level: row index in, edge cosines by a cordic cell chain, widths, area, ratios out
// depends on lcg_pkg, lcg_cordic_cell and lcg_ratio_div
//
//  channel  direction  handshake                 word
//  in       sink       i_in_valid / o_in_stall   i_row_index
//  out      source     o_out_valid / i_out_stall widths, area, three ratios, flag
//  cfg      sink       i_cfg_we                  i_cfg_index, i_cfg_data
//
// one row word per cycle while the pipeline is not held; the depth is set by
// the modulo stages, the cordic cell chain and the 33-bit quotient pipelines
// synchronous active-low reset clears valids, output valid and the config registers
// the pipeline holds only while the output word is stalled and the last stage is full
`timescale 1ns / 1ps
`default_nettype none

module latitude_cell_geometry #(
    parameter int CORDIC_STEPS = lcg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [lcg_pkg::ROW_W-1:0]               i_row_index,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [lcg_pkg::EW_OUT_W-1:0]     o_ew_width,
    output logic [lcg_pkg::NS_W-1:0]                o_ns_width,
    output logic signed [lcg_pkg::AREA_W-1:0]       o_cell_area,
    output logic signed [lcg_pkg::RATIO_W-1:0]      o_ratio_ew_face,
    output logic signed [lcg_pkg::RATIO_W-1:0]      o_ratio_north_face,
    output logic signed [lcg_pkg::RATIO_W-1:0]      o_ratio_south_face,
    output logic                                    o_area_negative,
    input  logic                                    i_cfg_we,
    input  logic [lcg_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [lcg_pkg::CFG_W-1:0]               i_cfg_data
);
    import lcg_pkg::*;

    localparam int LAT = 10 + MOD_STAGES + CORDIC_STEPS + DIV_LAT;

    typedef struct packed {
        logic [EW_OUT_W-1:0]       ew;
        logic [NS_W-1:0]           ns;
        logic signed [APROD_W-1:0] prod;
    } t_side;

    // config and derived widths
    logic signed [SOUTH_W-1:0] r_south;
    logic [STEP_W-1:0]         r_ns_step;
    logic [STEP_W-1:0]         r_ew_step;
    logic [44:0]               r_ns_lo;
    logic [43:0]               r_ns_hi;
    logic [44:0]               r_ew_lo;
    logic [43:0]               r_ew_hi;
    logic [61:0]               ns_sum;
    logic [61:0]               base_sum;
    logic [NS_W-1:0]           r_ns_w;
    logic [BASE_W-1:0]         r_base;

    // control
    logic           en;
    logic [LAT-1:0] r_v;
    logic           r_out_valid;

    // pipeline
    logic [39:0]        row_prod;
    logic [LAT_W-1:0]   n_a_lat;
    logic [LAT_W-1:0]   r_a_lat;
    logic [LAT_W-1:0]   r_b_lat [2];
    logic [LAT_W-1:0]   c_sum [2];
    logic [RED_W-1:0]   r_c [2];
    logic [RED_W-1:0]   red [MOD_STAGES+1][2];
    logic [RED_W-1:0]   e_sub [2];
    logic [FOLD_W-1:0]  r_e [2];
    logic [FOLD_W-1:0]  f_sub [2];
    t_lane [1:0]        n_f;
    t_lane [1:0]        r_f;
    t_lane [1:0]        lane [CORDIC_STEPS+1];
    logic signed [XY_W-1:0]   r_h_cos [2];
    logic signed [PROD_W-1:0] r_i_prod [2];
    logic signed [PROD_W-1:0] j_sum [2];
    logic signed [EDGE_W-1:0] r_j_edge [2];
    logic [EW_W:0]            k_sum;
    logic signed [EW_W-1:0]   r_k_ew;
    logic signed [EDGE_W-1:0] r_k_edge [2];
    t_side                    r_l_side;
    logic signed [NUM0_W-1:0] r_l_num0;
    logic signed [DEN0_W-1:0] r_l_den0;
    logic signed [NUM1_W-1:0] r_l_num_n;
    logic signed [NUM1_W-1:0] r_l_num_s;
    logic signed [DEN1_W-1:0] r_l_den1;
    t_side                    r_side [DIV_LAT];
    logic signed [RATIO_W-1:0] quo_ew;
    logic signed [RATIO_W-1:0] quo_n;
    logic signed [RATIO_W-1:0] quo_s;
    logic [APROD_W-1:0]        area_sum;

    // output word
    logic [EW_OUT_W-1:0] r_out_ew;
    logic [NS_W-1:0]     r_out_ns;
    logic [AREA_W-1:0]   r_out_area;
    logic [RATIO_W-1:0]  r_out_rew;
    logic [RATIO_W-1:0]  r_out_rn;
    logic [RATIO_W-1:0]  r_out_rs;
    logic                r_out_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_south   <= SOUTH_RESET;
            r_ns_step <= STEP_RESET;
            r_ew_step <= STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOUTH_EDGE: r_south   <= i_cfg_data;
                CFG_NS_STEP:    r_ns_step <= i_cfg_data[STEP_W-1:0];
                CFG_EW_STEP:    r_ew_step <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // metres per degree scaling, split into two partial products
    always_comb begin
        ns_sum   = (62'(r_ns_hi) << 17) + 62'(r_ns_lo) + 62'h8000_0000;
        base_sum = (62'(r_ew_hi) << 17) + 62'(r_ew_lo) + 62'h2000_0000;
    end

    always_ff @(posedge i_clk) begin
        r_ns_lo <= 45'(r_ns_step) * 45'(MPD_LO);
        r_ns_hi <= 44'(r_ns_step) * 44'(MPD_HI);
        r_ew_lo <= 45'(r_ew_step) * 45'(MPD_LO);
        r_ew_hi <= 44'(r_ew_step) * 44'(MPD_HI);
        r_ns_w  <= ns_sum[60:32];
        r_base  <= base_sum[60:30];
    end

    assign en         = !(r_out_valid && i_out_stall && r_v[LAT-1]);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (en) begin
                r_v <= {r_v[LAT-2:0], i_in_valid};
            end
            if (en && r_v[LAT-1]) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // south edge latitude
    always_comb begin
        row_prod = 40'(i_row_index) * 40'(r_ns_step);
        n_a_lat  = {{(LAT_W-SOUTH_W){r_south[SOUTH_W-1]}}, r_south}
                 + {{(LAT_W-40){1'b0}}, row_prod};
    end

    // lane 0 south, lane 1 north
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            c_sum[l] = r_b_lat[l] + LAT_W'(DEG_FULL);
            e_sub[l] = DEG_FULL - red[MOD_STAGES][l];
            f_sub[l] = DEG_HALF_F - r_e[l];
            n_f[l].x   = CORDIC_GAIN;
            n_f[l].y   = '0;
            n_f[l].neg = r_e[l] > DEG_QUARTER_F;
            n_f[l].z   = n_f[l].neg ? {1'b0, f_sub[l]} : {1'b0, r_e[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_lat    <= n_a_lat;
            r_b_lat[0] <= r_a_lat;
            r_b_lat[1] <= r_a_lat + {{(LAT_W-STEP_W){1'b0}}, r_ns_step};
            for (int l = 0; l < 2; l++) begin
                r_c[l] <= r_b_lat[l][LAT_W-1] ? c_sum[l][RED_W-1:0] : r_b_lat[l][RED_W-1:0];
                r_e[l] <= (red[MOD_STAGES][l] > DEG_HALF) ? e_sub[l][FOLD_W-1:0]
                                                         : red[MOD_STAGES][l][FOLD_W-1:0];
            end
            r_f <= n_f;
        end
    end

    // modulo full turn by conditional subtraction of shifted multiples
    assign red[0][0] = r_c[0];
    assign red[0][1] = r_c[1];

    for (genvar g = 0; g < MOD_STAGES; g++) begin : g_mod
        localparam logic [RED_W-1:0] MK = DEG_FULL << (MOD_STAGES - 1 - g);
        logic [RED_W-1:0] r_q [2];
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int l = 0; l < 2; l++) begin
                    r_q[l] <= (red[g][l] >= MK) ? red[g][l] - MK : red[g][l];
                end
            end
        end
        assign red[g+1][0] = r_q[0];
        assign red[g+1][1] = r_q[1];
    end

    assign lane[0] = r_f;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        lcg_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (lane[g]),
            .o_lane (lane[g+1])
        );
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            j_sum[l] = r_i_prod[l] + 65'sd2147483648;
        end
        k_sum = {r_j_edge[0][EDGE_W-1], r_j_edge[0]} + {r_j_edge[1][EDGE_W-1], r_j_edge[1]};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                r_h_cos[l]  <= lane[CORDIC_STEPS][l].neg ? -lane[CORDIC_STEPS][l].x
                                                         : lane[CORDIC_STEPS][l].x;
                r_i_prod[l] <= r_h_cos[l] * $signed({1'b0, r_base});
                r_j_edge[l] <= j_sum[l][63:32];
                r_k_edge[l] <= r_j_edge[l];
            end
            r_k_ew        <= k_sum[EW_W:1];
            r_l_side.ew   <= r_k_ew[EW_OUT_W-1:0];
            r_l_side.ns   <= r_ns_w;
            r_l_side.prod <= $signed({1'b0, r_ns_w}) * r_k_ew;
            r_l_num0      <= {1'b0, r_ns_w, 16'b0};
            r_l_den0      <= r_k_ew;
            r_l_num_n     <= {r_k_edge[1], 16'b0};
            r_l_num_s     <= {r_k_edge[0], 16'b0};
            r_l_den1      <= {1'b0, r_ns_w};
            r_side[0]     <= r_l_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    lcg_ratio_div #(
        .NUM_W (NUM0_W),
        .DEN_W (DEN0_W)
    ) u_div_ew (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_l_num0),
        .i_den (r_l_den0),
        .o_quo (quo_ew)
    );

    lcg_ratio_div #(
        .NUM_W (NUM1_W),
        .DEN_W (DEN1_W)
    ) u_div_north (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_l_num_n),
        .i_den (r_l_den1),
        .o_quo (quo_n)
    );

    lcg_ratio_div #(
        .NUM_W (NUM1_W),
        .DEN_W (DEN1_W)
    ) u_div_south (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_l_num_s),
        .i_den (r_l_den1),
        .o_quo (quo_s)
    );

    assign area_sum = r_side[DIV_LAT-1].prod + 62'sd32768;

    always_ff @(posedge i_clk) begin
        if (en && r_v[LAT-1]) begin
            r_out_ew   <= r_side[DIV_LAT-1].ew;
            r_out_ns   <= r_side[DIV_LAT-1].ns;
            r_out_area <= area_sum[57:16];
            r_out_neg  <= r_side[DIV_LAT-1].prod[APROD_W-1];
            r_out_rew  <= quo_ew;
            r_out_rn   <= quo_n;
            r_out_rs   <= quo_s;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_ew_width         = r_out_ew;
    assign o_ns_width         = r_out_ns;
    assign o_cell_area        = r_out_area;
    assign o_ratio_ew_face    = r_out_rew;
    assign o_ratio_north_face = r_out_rn;
    assign o_ratio_south_face = r_out_rs;
    assign o_area_negative    = r_out_neg;

endmodule

`default_nettype wire

// ----- design/lcg_checker.sv -----
// port-level checks for latitude_cell_geometry, bound to the top level
// depends on latitude_cell_geometry_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "latitude_cell_geometry_macros.svh"

module lcg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [29:0] o_ew_width,
    input logic signed [41:0] o_cell_area,
    input logic               o_area_negative
);

    `LCG_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_ew_width) && $stable(o_cell_area), "stalled output word changed")
    `LCG_ASSERT_IMPL(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled without output backpressure")
    `LCG_ASSERT_IMPL(a_neg_ew_sign, o_out_valid && o_area_negative, o_ew_width[29], "negative area with nonnegative ew width")
    `LCG_ASSERT_IMPL(a_neg_area_sign, o_out_valid && o_area_negative, o_cell_area[41] || (o_cell_area == 42'sd0), "negative area flag with positive area")

endmodule

bind latitude_cell_geometry lcg_checker u_lcg_checker (.*);

`default_nettype wire

// ----- test/latitude_cell_geometry_tb.sv -----
// testbench for latitude_cell_geometry: row words in, cell widths, area and face ratios out
// depends on lcg_pkg and the rtl; expected words come from an in-bench fixed-point predictor
`timescale 1ns / 1ps

module latitude_cell_geometry_tb;
    import lcg_pkg::*;

    localparam longint DEG_FULL_L = 64'sd6039797760;
    localparam longint DEG_HALF_L = 64'sd3019898880;
    localparam longint DEG_QTR_L = 64'sd1509949440;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic signed [EW_OUT_W-1:0] ew;
        logic [NS_W-1:0] ns;
        logic signed [AREA_W-1:0] area;
        logic signed [RATIO_W-1:0] r_ew;
        logic signed [RATIO_W-1:0] r_north;
        logic signed [RATIO_W-1:0] r_south;
        logic neg;
    } cell_geom_t;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic [ROW_W-1:0] i_row_index;
    logic o_out_valid;
    logic i_out_stall;
    logic signed [EW_OUT_W-1:0] o_ew_width;
    logic [NS_W-1:0] o_ns_width;
    logic signed [AREA_W-1:0] o_cell_area;
    logic signed [RATIO_W-1:0] o_ratio_ew_face;
    logic signed [RATIO_W-1:0] o_ratio_north_face;
    logic signed [RATIO_W-1:0] o_ratio_south_face;
    logic o_area_negative;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    latitude_cell_geometry DUT (.*);

    // predictor copy of the registers
    longint south_edge;
    longint unsigned ns_step;
    longint unsigned ew_step;

    cell_geom_t geom_q[$];
    int mismatches = 0;
    bit send_idle = 1;
    bit recv_idle = 1;
    int taken_cnt = 0;
    int taken_seen = 0;
    int stall_left = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint cos_q30(longint lat);
        longint a;
        longint x;
        longint y;
        longint nx;
        bit flip;
        a = lat % DEG_FULL_L;
        x = longint'(CORDIC_GAIN);
        y = 0;
        flip = 0;
        if (a < 0) a += DEG_FULL_L;
        if (a > DEG_HALF_L) a = DEG_FULL_L - a;
        if (a > DEG_QTR_L) begin
            a = DEG_HALF_L - a;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            if (a >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                a -= longint'(ATAN_DEG[i]);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                a += longint'(ATAN_DEG[i]);
            end
            x = nx;
        end
        return flip ? -x : x;
    endfunction

    function automatic logic [31:0] face_ratio(longint num, longint den);
        longint q;
        if (den == 0) begin
            if (num > 0) return 32'h7FFF_FFFF;
            if (num < 0) return 32'h8000_0000;
            return 32'h0;
        end
        q = (num * 65536) / den;
        if (q > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (q < -64'sd2147483648) return 32'h8000_0000;
        return q[31:0];
    endfunction

    function automatic cell_geom_t predict_geom(logic [ROW_W-1:0] row);
        cell_geom_t g;
        longint lat_s;
        longint lat_n;
        longint ns;
        longint base;
        longint edge_n;
        longint edge_s;
        longint ew;
        longint prod;
        longint area;
        lat_s = south_edge + longint'(row) * longint'(ns_step);
        lat_n = lat_s + longint'(ns_step);
        ns = longint'((ns_step * longint'(MPD_Q16) + 64'h8000_0000) >> 32);
        base = longint'((ew_step * longint'(MPD_Q16) + 64'h2000_0000) >> 30);
        edge_n = (base * cos_q30(lat_n) + 64'sh8000_0000) >>> 32;
        edge_s = (base * cos_q30(lat_s) + 64'sh8000_0000) >>> 32;
        ew = (edge_n + edge_s) >>> 1;
        prod = ns * ew;
        area = (prod + 32768) >>> 16;
        g.ew = ew[EW_OUT_W-1:0];
        g.ns = ns[NS_W-1:0];
        g.area = area[AREA_W-1:0];
        g.r_ew = face_ratio(ns, ew);
        g.r_north = face_ratio(edge_n, ns);
        g.r_south = face_ratio(edge_s, ns);
        g.neg = prod < 0;
        return g;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        cell_geom_t exp_g;
        cell_geom_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            taken_cnt <= taken_cnt + 1;
            got = '{o_ew_width, o_ns_width, o_cell_area, o_ratio_ew_face,
                    o_ratio_north_face, o_ratio_south_face, o_area_negative};
            if (geom_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                mismatches++;
            end else begin
                exp_g = geom_q.pop_front();
                if (got !== exp_g) begin
                    $display("%0t: expected ew %0d ns %0d area %0d r %h %h %h neg %b",
                             $time, exp_g.ew, exp_g.ns, exp_g.area, exp_g.r_ew,
                             exp_g.r_north, exp_g.r_south, exp_g.neg);
                    $display("%0t: actual   ew %0d ns %0d area %0d r %h %h %h neg %b",
                             $time, got.ew, got.ns, got.area, got.r_ew,
                             got.r_north, got.r_south, got.neg);
                    mismatches++;
                end
            end
        end
    end

    // output stall driver
    always @(negedge i_clk) begin
        int s;
        s = stall_left;
        if (taken_cnt != taken_seen) begin
            taken_seen = taken_cnt;
            s = recv_idle ? $urandom_range(0, 7) : 0;
        end
        i_out_stall <= (s != 0);
        stall_left <= (s != 0) ? s - 1 : 0;
    end

    task automatic send_row(logic [ROW_W-1:0] row);
        int gap;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1;
        i_row_index <= row;
        do @(posedge i_clk); while (o_in_stall);
        geom_q.push_back(predict_geom(row));
    endtask

    task automatic drain();
        @(negedge i_clk) i_in_valid <= 0;
        while (geom_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk) i_cfg_we <= 0;
        case (idx)
            CFG_SOUTH_EDGE: south_edge = longint'(signed'(val));
            CFG_NS_STEP: ns_step = val[STEP_W-1:0];
            CFG_EW_STEP: ew_step = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [31:0] south, logic [31:0] ns_s, logic [31:0] ew_s);
        write_reg(CFG_SOUTH_EDGE, south);
        write_reg(CFG_NS_STEP, ns_s);
        write_reg(CFG_EW_STEP, ew_s);
    endtask

    task automatic test_reset_grid();
        send_row(12'd0);
        send_row(12'd1);
        send_row(12'd2048);
        send_row(12'hFFF);
        send_row(12'hAAA);
        send_row(12'h555);
    endtask

    task automatic test_extreme_grids();
        // northern edge limit with the widest spacings, southern edge limit with the narrowest
        set_grid(32'd1509949440, 32'd167772160, 32'd167772160);
        send_row(12'd0);
        send_row(12'hFFF);
        send_row(12'd7);
        set_grid(-32'sd1509949440, 32'd1, 32'd1);
        send_row(12'd0);
        send_row(12'hFFF);
        // all ones on every register bit
        set_grid(32'hFFFF_FFFF, 32'h0FFF_FFFF, 32'h0FFF_FFFF);
        send_row(12'd0);
        send_row(12'hFFF);
        set_grid(32'h8000_0000, 32'h0FFF_FFFF, 32'd139810);
        send_row(12'd3);
    endtask

    task automatic test_zero_spacing();
        set_grid(32'd0, 32'd0, 32'd139810);
        send_row(12'd0);
        send_row(12'hFFF);
        write_reg(CFG_EW_STEP, 32'd0);
        send_row(12'd5);
        write_reg(CFG_NS_STEP, 32'd139810);
        send_row(12'd5);
    endtask

    task automatic test_wrap_and_negative_area();
        // rows run past the pole, cosine goes negative, area flag set
        set_grid(32'd1400000000, 32'd100000000, 32'd1000000);
        for (int r = 0; r < 6; r++) send_row(ROW_W'(r));
        send_row(12'd100);
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 8; p++) begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0)
                set_grid($urandom, $urandom_range(0, 32'h0FFF_FFFF), $urandom);
            else
                set_grid(32'(int'($urandom_range(0, 3019898880)) - 1509949440),
                         $urandom_range(1, 167772160), $urandom_range(1, 167772160));
            for (int n = 0; n < 95; n++) begin
                send_row(ROW_W'($urandom_range(0, 4095)));
                // hold off until the pipeline has emptied once per phase
                if (n == 40) begin
                    @(negedge i_clk) i_in_valid <= 0;
                    while (geom_q.size() != 0) @(posedge i_clk);
                end
            end
        end
        send_idle = 1;
        recv_idle = 1;
    endtask

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_row_index = '0;
        i_cfg_we = 0;
        i_cfg_index = CFG_SOUTH_EDGE;
        i_cfg_data = '0;
        south_edge = longint'(SOUTH_RESET);
        ns_step = STEP_RESET;
        ew_step = STEP_RESET;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1;
        test_reset_grid();
        test_extreme_grids();
        test_zero_spacing();
        test_wrap_and_negative_area();
        test_random_phases();
        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/lcg_pkg.sv
design/lcg_cordic_cell.sv
design/lcg_div_cell.sv
design/lcg_ratio_div.sv
design/latitude_cell_geometry.sv
design/lcg_checker.sv
test/latitude_cell_geometry_tb.sv
